// ===== hdl/dsp_pkg.sv =====
// Shared types and constants for the Doppler spectrum to pixel converter.
`default_nettype none
package dsp_pkg;
	localparam int IDX_W   = 6;
	localparam int MAG_W   = 16;
	localparam int PIX_W   = 8;
	localparam int ADDR_W  = IDX_W + 1;
	localparam int RAM_DEPTH = 2 ** ADDR_W;

	typedef struct packed {
		logic signed [15:0] bin_real;
		logic signed [15:0] bin_imag;
	} in_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic [IDX_W-1:0] pixel_position;
		logic             frame_done;
	} out_beat_t;

	// one finished frame waiting for pixel conversion
	typedef struct packed {
		logic [MAG_W-1:0] peak;
		logic [PIX_W-1:0] thr;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [MAG_W-1:0]  data;
	} ram_wr_t;

	typedef enum logic [2:0] {
		F_IDLE, F_SQUARE, F_SUM, F_ROOT, F_STORE
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE, B_READ, B_MUL, B_DIV, B_OUT
	} back_state_t;
endpackage
`default_nettype wire

// ===== hdl/dsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/dsp_front.sv =====
// Front end: takes bins, computes integer magnitude, stores it and tracks the frame peak.
`default_nettype none
module dsp_front #(
	parameter int BINS_PER_FRAME = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire dsp_pkg::in_beat_t in_beat,
	input  wire logic [7:0]       thr,
	input  wire logic             q_full,
	output logic                  job_push,
	output dsp_pkg::job_t         job,
	output dsp_pkg::ram_wr_t      ram_wr
);
	import dsp_pkg::*;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(BINS_PER_FRAME - 1);

	front_state_t     state_q, state_n;
	logic signed [15:0] re_q, im_q;
	logic [31:0]      sq_re_q, sq_im_q, pow_q;
	logic [17:0]      rem_q;
	logic [15:0]      root_q;
	logic [3:0]       step_q;
	logic [MAG_W-1:0] peak_q, peak_n;
	logic [IDX_W-1:0] cnt_q;
	logic             bank_q;
	logic [19:0]      rem_sh, trial;
	logic             take;
	logic             accept, last;

	assign accept = in_valid && !in_stall;
	assign last   = (cnt_q == LAST);

	// one root digit per cycle
	assign rem_sh = {rem_q, pow_q[31:30]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign take   = (rem_sh >= trial);
	assign peak_n = (root_q > peak_q) ? root_q : peak_q;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			F_IDLE:   if (accept) state_n = F_SQUARE;
			F_SQUARE: state_n = F_SUM;
			F_SUM:    state_n = F_ROOT;
			F_ROOT:   if (step_q == 4'd0) state_n = F_STORE;
			F_STORE:  state_n = F_IDLE;
			default:  state_n = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall     = (state_q != F_IDLE) || q_full;
		ram_wr.en    = (state_q == F_STORE);
		ram_wr.addr  = {bank_q, cnt_q};
		ram_wr.data  = root_q;
		job_push     = (state_q == F_STORE) && last;
		job.peak     = peak_n;
		job.thr      = thr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			peak_q  <= '0;
			cnt_q   <= '0;
			bank_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == F_STORE) begin
				if (last) begin
					peak_q <= '0;
					cnt_q  <= '0;
					bank_q <= ~bank_q;
				end else begin
					peak_q <= peak_n;
					cnt_q  <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					re_q <= in_beat.bin_real;
					im_q <= in_beat.bin_imag;
				end
			end
			F_SQUARE: begin
				sq_re_q <= 32'(re_q * re_q);
				sq_im_q <= 32'(im_q * im_q);
			end
			F_SUM: begin
				pow_q  <= sq_re_q + sq_im_q;
				rem_q  <= '0;
				root_q <= '0;
				step_q <= 4'd15;
			end
			F_ROOT: begin
				pow_q  <= {pow_q[29:0], 2'b00};
				step_q <= step_q - 1'b1;
				if (take) begin
					rem_q  <= 18'(rem_sh - trial);
					root_q <= {root_q[14:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[17:0];
					root_q <= {root_q[14:0], 1'b0};
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/dsp_back.sv =====
// Back end: reads stored magnitudes, scales by the frame peak, thresholds and emits pixels.
`default_nettype none
module dsp_back #(
	parameter int BINS_PER_FRAME = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	input  wire dsp_pkg::job_t     job,
	output logic                   job_pop,
	output logic                   rd_en,
	output logic [dsp_pkg::ADDR_W-1:0] rd_addr,
	input  wire logic [dsp_pkg::MAG_W-1:0] rd_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output dsp_pkg::out_beat_t     out_beat
);
	import dsp_pkg::*;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(BINS_PER_FRAME - 1);
	localparam logic [IDX_W:0]   HALF = (IDX_W+1)'(BINS_PER_FRAME / 2);

	back_state_t      state_q, state_n;
	logic [IDX_W-1:0] idx_q;
	logic             bank_q;
	logic [15:0]      rem_q;
	logic [7:0]       lo_q, quo_q;
	logic [2:0]       step_q;
	logic [23:0]      prod;
	logic [16:0]      rem_sh;
	logic             qbit;
	logic [7:0]       quo_n, pix;
	logic [IDX_W:0]   i7, pos;
	logic             out_acc;
	out_beat_t        beat_q;

	assign out_acc = out_valid && !out_stall;
	assign prod    = {rd_data, 8'h00} - {8'h00, rd_data};
	assign rem_sh  = {rem_q, lo_q[7]};
	assign qbit    = (rem_sh >= {1'b0, job.peak});
	assign quo_n   = {quo_q[6:0], qbit};
	assign pix     = (job.peak == '0 || quo_n < job.thr) ? 8'h00 : quo_n;
	assign i7      = {1'b0, idx_q};
	assign pos     = (i7 <= HALF) ? (i7 + HALF - 1'b1) : (i7 - HALF - 1'b1);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			B_IDLE:  if (job_valid) state_n = B_READ;
			B_READ:  state_n = B_MUL;
			B_MUL:   state_n = B_DIV;
			B_DIV:   if (step_q == 3'd0) state_n = B_OUT;
			B_OUT: begin
				if (out_acc) state_n = (idx_q == LAST) ? B_IDLE : B_READ;
			end
			default: state_n = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rd_en     = (state_q == B_READ);
		rd_addr   = {bank_q, idx_q};
		out_valid = (state_q == B_OUT);
		out_beat  = beat_q;
		job_pop   = out_acc && (idx_q == LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
			bank_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_acc) begin
				if (idx_q == LAST) begin
					idx_q  <= '0;
					bank_q <= ~bank_q;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// restoring divide, one quotient bit a cycle
	always_ff @(posedge clk) begin
		case (state_q)
			B_MUL: begin
				rem_q  <= prod[23:8];
				lo_q   <= prod[7:0];
				quo_q  <= '0;
				step_q <= 3'd7;
			end
			B_DIV: begin
				lo_q   <= {lo_q[6:0], 1'b0};
				quo_q  <= quo_n;
				step_q <= step_q - 1'b1;
				rem_q  <= qbit ? 16'(rem_sh - {1'b0, job.peak}) : rem_sh[15:0];
				if (step_q == 3'd0) begin
					beat_q.pixel_value    <= pix;
					beat_q.pixel_position <= pos[IDX_W-1:0];
					beat_q.frame_done     <= (idx_q == LAST);
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/doppler_spectrum_to_pixels.sv =====
// Top level: Doppler spectrum bins in, normalized spectrum-shifted pixels out.
//
//  channel  direction  handshake            beat
//  in       input      in_valid / in_stall  in_beat  (bin_real, bin_imag)
//  out      output     out_valid/out_stall  out_beat (pixel_value, pixel_position, frame_done)
//  cfg      input      cfg_we               cfg_wdata (pixel_threshold)
//
// Each bin passes through the front end in order: accept, square, sum, the
// one-digit-a-cycle square root and store. Each pixel passes through the back end
// as RAM read, scale, 8-step divide by the peak, then output until it is taken.
// A two-bank magnitude RAM and a two-entry frame queue let the next frame load
// while the previous one drains; input stalls when both banks are pending.
// Reset clears control state and the threshold; the RAM needs no clearing.
`default_nettype none
module doppler_spectrum_to_pixels #(
	parameter int BINS_PER_FRAME = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire dsp_pkg::in_beat_t  in_beat,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output dsp_pkg::out_beat_t      out_beat,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_wdata
);
	import dsp_pkg::*;

	logic [7:0]        thr_q;
	logic              job_push, job_pop;
	job_t              job_in;
	job_t              q_mem_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        q_cnt_q;
	ram_wr_t           ram_wr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [MAG_W-1:0]  rd_data;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	dsp_front #(.BINS_PER_FRAME(BINS_PER_FRAME)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.thr      (thr_q),
		.q_full   (q_cnt_q == 2'd2),
		.job_push (job_push),
		.job      (job_in),
		.ram_wr   (ram_wr)
	);

	// frame queue between front and back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			q_cnt_q <= '0;
		end else begin
			if (job_push) wp_q <= ~wp_q;
			if (job_pop)  rp_q <= ~rp_q;
			q_cnt_q <= q_cnt_q + {1'b0, job_push} - {1'b0, job_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (job_push) begin
			q_mem_q[wp_q] <= job_in;
		end
	end

	dsp_ram #(.WIDTH(MAG_W), .DEPTH(RAM_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr.en),
		.wr_addr (ram_wr.addr),
		.wr_data (ram_wr.data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dsp_back #(.BINS_PER_FRAME(BINS_PER_FRAME)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_cnt_q != 2'd0),
		.job       (q_mem_q[rp_q]),
		.job_pop   (job_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

	// checks
	a_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> (q_cnt_q != 2'd2)) else $error("frame queue overflow");
	a_q_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> (q_cnt_q != 2'd0)) else $error("frame queue underflow");
	a_done_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_beat.frame_done) |-> job_pop)
		else $error("last pixel did not retire its frame");
	a_out_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (q_cnt_q != 2'd0)) else $error("pixel without pending frame");
endmodule
`default_nettype wire

// ===== tb/doppler_pixel_checker.sv =====
// Checker for the Doppler spectrum to pixel converter: frame predictor and pixel comparison.
`timescale 1ns / 1ps
module doppler_pixel_checker #(
	parameter int BINS_PER_FRAME = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire dsp_pkg::in_beat_t  in_beat,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire dsp_pkg::out_beat_t out_beat,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_wdata,
	output int                      fail_count,
	output int                      pixels_pending,
	output int                      pixels_seen
);
	import dsp_pkg::*;

	localparam int HALF = BINS_PER_FRAME / 2;

	// predicted frame state
	logic [MAG_W-1:0] frame_mags [BINS_PER_FRAME];
	logic [MAG_W-1:0] frame_peak;
	int               bins_loaded;
	logic [7:0]       threshold;
	out_beat_t        expected_pixels [$];

	// bitwise integer square root, one result bit per pass
	function automatic logic [MAG_W-1:0] int_sqrt(input logic [31:0] v);
		logic [31:0] root;
		logic [31:0] bit_w;
		root  = 0;
		bit_w = 32'h4000_0000;
		while (bit_w > v) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= root + bit_w) begin
				v    = v - (root + bit_w);
				root = (root >> 1) + bit_w;
			end else begin
				root = root >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return root[MAG_W-1:0];
	endfunction

	// take one bin; on the last bin queue every pixel of the frame
	task automatic load_bin(input in_beat_t b);
		logic signed [31:0] re, im;
		logic [31:0]        power;
		logic [31:0]        pix;
		logic [MAG_W-1:0]   mag;
		out_beat_t          px;
		re    = b.bin_real;
		im    = b.bin_imag;
		power = 32'(re * re) + 32'(im * im);
		mag   = int_sqrt(power);
		frame_mags[bins_loaded] = mag;
		if (mag > frame_peak) frame_peak = mag;
		bins_loaded++;
		if (bins_loaded == BINS_PER_FRAME) begin
			for (int i = 0; i < BINS_PER_FRAME; i++) begin
				pix = 0;
				if (frame_peak != 0) pix = (32'd255 * frame_mags[i]) / frame_peak;
				if (pix > 255) pix = 255;
				if (pix < threshold) pix = 0;
				px.pixel_value    = pix[7:0];
				px.pixel_position = (i <= HALF) ? IDX_W'(i + HALF - 1) : IDX_W'(i - HALF - 1);
				px.frame_done     = (i == BINS_PER_FRAME - 1);
				expected_pixels = {expected_pixels, px};
			end
			bins_loaded = 0;
			frame_peak  = 0;
		end
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count     = 0;
		pixels_seen    = 0;
		pixels_pending = 0;
	end

	// watch all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			frame_peak  = 0;
			bins_loaded = 0;
			threshold   = 0;
			expected_pixels.delete();
		end else begin
			if (cfg_we) threshold = cfg_wdata;
			if (in_valid && !in_stall) load_bin(in_beat);
			if (out_valid && !out_stall) begin
				pixels_seen++;
				if (expected_pixels.size() == 0) begin
					report("unexpected pixel, value", out_beat.pixel_value, -1);
				end else begin
					want = expected_pixels.pop_front();
					if (out_beat.pixel_value != want.pixel_value)
						report("pixel_value", out_beat.pixel_value, want.pixel_value);
					if (out_beat.pixel_position != want.pixel_position)
						report("pixel_position", out_beat.pixel_position, want.pixel_position);
					if (out_beat.frame_done != want.frame_done)
						report("frame_done", out_beat.frame_done, want.frame_done);
				end
			end
		end
		pixels_pending = expected_pixels.size();
	end
endmodule

// ===== tb/tb_doppler_spectrum_to_pixels.sv =====
// Testbench top: bin stimulus, threshold settings and verdict for the pixel converter.
`timescale 1ns / 1ps
module tb_doppler_spectrum_to_pixels;
	import dsp_pkg::*;

	localparam int BINS      = 64;
	localparam int MAX_CYCLES = 600000;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_stall;
	in_beat_t  in_beat = '0;
	logic      out_valid;
	logic      out_stall = 0;
	out_beat_t out_beat;
	logic      cfg_we = 0;
	logic [7:0] cfg_wdata = 0;
	int        fail_count, pixels_pending, pixels_seen;
	int        cycle_count = 0;
	int        stall_max = 9;
	int        gap_max = 9;
	int        frames_sent = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	doppler_spectrum_to_pixels #(.BINS_PER_FRAME(BINS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
		.out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	doppler_pixel_checker #(.BINS_PER_FRAME(BINS)) i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
		.out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pixels_pending(pixels_pending),
		.pixels_seen(pixels_seen)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d pixels outstanding",
				cycle_count, pixels_pending);
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stall before each pixel beat
	always @(negedge clk) begin
		int hold;
		if (arst_n && out_valid && !out_stall) begin
			hold = $urandom_range(0, stall_max);
			if (hold > 0) begin
				out_stall = 1;
				repeat (hold) @(negedge clk);
				out_stall = 0;
			end
			// let this beat pass, then look at the next one
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	// one bin beat, with a random gap ahead of it
	task automatic send_bin(input logic signed [15:0] re, input logic signed [15:0] im);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_beat.bin_real = re;
		in_beat.bin_imag = im;
		in_valid = 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// threshold write while the block is idle
	task automatic set_threshold(input logic [7:0] thr);
		in_valid = 0;
		wait (pixels_pending == 0);
		repeat (40) @(negedge clk);
		cfg_wdata = thr;
		cfg_we = 1;
		@(negedge clk);
		cfg_we = 0;
	endtask

	// random bins; the magnitude range sweeps from tiny to full scale
	task automatic random_bins(input int count);
		logic signed [15:0] re, im;
		int                 amp_bits;
		for (int i = 0; i < count; i++) begin
			amp_bits = 2 + (i % 15);
			re = 16'($urandom);
			im = 16'($urandom);
			if (amp_bits < 16) begin
				re = re >>> (16 - amp_bits);
				im = im >>> (16 - amp_bits);
			end
			send_bin(re, im);
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1;

		// all-zero frame: no peak, every pixel zero
		set_threshold(8'd0);
		for (int i = 0; i < BINS; i++) send_bin(16'sd0, 16'sd0);
		frames_sent++;

		// field extremes first, then random bins, at mid threshold
		set_threshold(8'd128);
		for (int i = 0; i < 8; i++) begin
			case (i)
				0: send_bin(-16'sd32768, -16'sd32768);
				1: send_bin(16'sd32767, 16'sd32767);
				2: send_bin(-16'sd32768, 16'sd0);
				3: send_bin(16'sd0, 16'sd32767);
				4: send_bin(16'sd1, -16'sd1);
				5: send_bin(-16'sd1, 16'sd0);
				6: send_bin(16'sd0, 16'sd0);
				default: send_bin(16'sd32767, -16'sd32768);
			endcase
		end
		random_bins(BINS - 8);
		frames_sent++;
		in_valid = 0;

		wait (pixels_pending == 0);
		repeat (200) @(negedge clk);
		$display("ran %0d frames of %0d bins, %0d pixels checked", frames_sent, BINS, pixels_seen);
		$display("thresholds 0 and 128; zero, extreme and random bins under random stalls");
		if (fail_count == 0 && pixels_pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== files.f =====
hdl/dsp_pkg.sv
hdl/dsp_ram.sv
hdl/dsp_front.sv
hdl/dsp_back.sv
hdl/doppler_spectrum_to_pixels.sv
tb/doppler_pixel_checker.sv
tb/tb_doppler_spectrum_to_pixels.sv
